>>> hw/rtl/mdw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mdw_pkg: shared definitions of the multi-slot deadline watchdog
// sizes, operation/event/status codes, controller states and the
// command/status bundles between controller and datapath
// ----------------------------------------------------------------------------
package mdw_pkg;

    localparam int SLOTS      = 16;
    localparam int SLOT_BITS  = $clog2(SLOTS);
    localparam int COUNT_BITS = $clog2(SLOTS + 1);
    localparam int TIME_BITS  = 48;

    // operation codes carried in s_tuser
    localparam logic [2:0] OP_ALLOC   = 3'd0;
    localparam logic [2:0] OP_RELEASE = 3'd1;
    localparam logic [2:0] OP_ARM     = 3'd2;
    localparam logic [2:0] OP_CONFIRM = 3'd3;
    localparam logic [2:0] OP_TICK    = 3'd4;

    // event codes
    localparam logic [2:0] EV_GRANT   = 3'd0;
    localparam logic [2:0] EV_RELEASE = 3'd1;
    localparam logic [2:0] EV_ARM     = 3'd2;
    localparam logic [2:0] EV_ONTIME  = 3'd3;
    localparam logic [2:0] EV_LATE    = 3'd4;
    localparam logic [2:0] EV_EXPIRED = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOFREE = 2'd1;
    localparam logic [1:0] ST_UNUSED = 2'd2;
    localparam logic [1:0] ST_NONE   = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_FLUSH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;       // latch accepted word, start memory read
        logic exec;       // finish a single-result operation
        logic scan_step;  // check current scan slot and advance
        logic flush;      // emit final result of a tick scan
    } cmd_t;

    // datapath to controller (and checks)
    typedef struct packed {
        logic [2:0]            op;
        logic                  out_free;
        logic                  scan_hit;
        logic                  scan_last;
        logic                  hold_valid;
        logic [COUNT_BITS-1:0] free_count;
        logic [SLOTS-1:0]      in_use;
        logic [SLOTS-1:0]      armed;
    } stat_t;

endpackage
`default_nettype wire

>>> hw/rtl/multi_slot_deadline_watchdog_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_slot_deadline_watchdog_core: multi-slot deadline watchdog
// slots from a fifo free list, armed with deadlines, confirmed or expired
// by a tick scan over all slots
// ----------------------------------------------------------------------------
//  channel  dir  tdata                                tuser                 tlast
//  s_       in   slot[3:0] timeout[51:4] now[99:52]   opcode[2:0]           -
//  m_       out  result_slot[3:0] lateness[51:4]      event_res[2:0] status[4:3]  last
//
//  allocate, release, arm and confirm are accepted, then executed
//  a tick is accepted, then steps through the slots via the deadline memory
//  read port and ends with a final flush; output stalls hold the scan
//  one word is in work at a time; the output register lets the next word
//  be accepted while a result waits; a full output stalls execution
//  reset (synchronous, active low) fills the free list with 0 to SLOTS-1
// ----------------------------------------------------------------------------
module multi_slot_deadline_watchdog_core (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [103:0] s_tdata,   // slot, timeout, now
    input  wire logic [2:0]   s_tuser,   // opcode
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [55:0]       m_tdata,   // result_slot, lateness
    output logic [4:0]        m_tuser,   // event_res, status
    output logic              m_tlast
);

    mdw_pkg::cmd_t   cmd;
    mdw_pkg::stat_t  stat;
    mdw_pkg::state_t state;

    mdw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_op     (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd),
        .state    (state)
    );

    mdw_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .s_op     (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .stat     (stat)
    );

    // every slot is either in use or on the free list
    a_slot_conservation: assert property (@(posedge aclk) disable iff (!aresetn)
        ($countones(stat.in_use) + int'(stat.free_count)) == mdw_pkg::SLOTS)
        else $error("slot count mismatch");

    // only slots in use can be armed
    a_armed_in_use: assert property (@(posedge aclk) disable iff (!aresetn)
        (stat.armed & ~stat.in_use) == '0)
        else $error("armed slot not in use");

    // single-result operations end with a last word
    a_exec_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && ((stat.op == mdw_pkg::OP_ALLOC) || (stat.op == mdw_pkg::OP_RELEASE)
            || (stat.op == mdw_pkg::OP_ARM) || (stat.op == mdw_pkg::OP_CONFIRM)))
        |=> (m_tvalid && m_tlast))
        else $error("exec without last result");

    // a finished scan always delivers a last word and returns to idle
    a_flush_last: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.flush |=> (m_tvalid && m_tlast && (state == mdw_pkg::S_IDLE)))
        else $error("scan flush without last result");

endmodule
`default_nettype wire

>>> hw/rtl/mdw_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mdw_ctrl: watchdog sequencer
// accepts one word at a time, runs single-result operations in one step and
// walks the slots one per cycle, unless the output stalls it, for a tick scan
// ----------------------------------------------------------------------------
module mdw_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    input  wire logic [2:0]     s_op,
    output logic                s_tready,
    input  wire mdw_pkg::stat_t stat,
    output mdw_pkg::cmd_t       cmd,
    output mdw_pkg::state_t     state
);

    mdw_pkg::state_t state_reg;
    mdw_pkg::state_t state_next;
    logic            accept;
    logic            scan_stall;

    assign accept     = s_tvalid && (state_reg == mdw_pkg::S_IDLE);
    // a second expired slot needs the output register before it can be held
    assign scan_stall = stat.scan_hit && stat.hold_valid && !stat.out_free;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mdw_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mdw_pkg::S_IDLE: begin
                if (accept) begin
                    if (s_op == mdw_pkg::OP_TICK) begin
                        state_next = mdw_pkg::S_SCAN;
                    end else if (s_op < mdw_pkg::OP_TICK) begin
                        state_next = mdw_pkg::S_EXEC;
                    end
                end
            end
            mdw_pkg::S_EXEC: begin
                if (stat.out_free) begin
                    state_next = mdw_pkg::S_IDLE;
                end
            end
            mdw_pkg::S_SCAN: begin
                if (!scan_stall && stat.scan_last) begin
                    state_next = mdw_pkg::S_FLUSH;
                end
            end
            mdw_pkg::S_FLUSH: begin
                if (stat.out_free) begin
                    state_next = mdw_pkg::S_IDLE;
                end
            end
            default: state_next = mdw_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_tready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            mdw_pkg::S_IDLE: begin
                s_tready = 1'b1;
                cmd.load = accept;
            end
            mdw_pkg::S_EXEC:  cmd.exec      = stat.out_free;
            mdw_pkg::S_SCAN:  cmd.scan_step = !scan_stall;
            mdw_pkg::S_FLUSH: cmd.flush     = stat.out_free;
            default: ;
        endcase
    end

    assign state = state_reg;

endmodule
`default_nettype wire

>>> hw/rtl/mdw_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mdw_datapath: watchdog storage and arithmetic
// deadline memory with armed bits, in-use bits, free slot fifo, scan hold
// register and the output register
// ----------------------------------------------------------------------------
module mdw_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire mdw_pkg::cmd_t                 cmd,
    input  wire logic [2:0]                    s_op,
    input  wire logic [103:0]                  s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [55:0]                        m_tdata,
    output logic [4:0]                         m_tuser,
    output logic                               m_tlast,
    output mdw_pkg::stat_t                     stat
);

    localparam int SB = mdw_pkg::SLOT_BITS;
    localparam int TB = mdw_pkg::TIME_BITS;
    localparam int CB = mdw_pkg::COUNT_BITS;
    localparam int NS = mdw_pkg::SLOTS;

    // input word fields
    logic [SB-1:0] in_slot;
    logic [TB-1:0] in_timeout;
    logic [TB-1:0] in_now;
    assign in_slot    = s_tdata[SB-1:0];
    assign in_timeout = s_tdata[4 +: TB];
    assign in_now     = s_tdata[4 + TB +: TB];

    // latched item
    logic [2:0]    op_reg;
    logic [SB-1:0] slot_reg;
    logic [TB-1:0] timeout_reg;
    logic [TB-1:0] now_reg;

    // deadline memory
    logic [TB-1:0] mem [NS];
    logic [TB-1:0] rd_data_reg;
    logic [SB-1:0] rd_addr;
    logic          rd_en;
    logic          mem_we;
    logic [TB-1:0] mem_wdata;

    // control state
    logic [NS-1:0] in_use_reg,  in_use_next;
    logic [NS-1:0] armed_reg,   armed_next;
    logic [SB-1:0] fifo_reg [NS];
    logic [SB-1:0] fifo_next [NS];
    logic [SB-1:0] head_reg,    head_next;
    logic [SB-1:0] tail_reg,    tail_next;
    logic [CB-1:0] count_reg,   count_next;
    logic [SB-1:0] scan_idx_reg, scan_idx_next;
    logic          hold_valid_reg, hold_valid_next;
    logic [SB-1:0] hold_slot_reg, hold_slot_next;
    logic [TB-1:0] hold_late_reg, hold_late_next;
    logic          m_tvalid_reg, m_tvalid_next;

    // output payload
    logic [2:0]    ev_reg;
    logic [1:0]    st_reg;
    logic [SB-1:0] rslot_reg;
    logic [TB-1:0] late_reg;
    logic          last_reg;

    // result push
    logic          push;
    logic [2:0]    push_ev;
    logic [1:0]    push_st;
    logic [SB-1:0] push_slot;
    logic [TB-1:0] push_late;
    logic          push_last;

    // arithmetic
    logic [TB:0]   arm_sum;
    logic [TB-1:0] arm_deadline;
    logic          past_due;
    logic [TB-1:0] over_time;
    logic          slot_valid;
    logic          scan_last;
    logic          scan_hit;
    logic          out_free;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign scan_last = (scan_idx_reg == SB'(NS - 1));

    // deadline sum saturates; a zero result is stored as one
    assign arm_sum = {1'b0, now_reg} + {1'b0, timeout_reg};
    always_comb begin
        arm_deadline = arm_sum[TB] ? {TB{1'b1}} : arm_sum[TB-1:0];
        if (arm_deadline == '0) begin
            arm_deadline = TB'(1);
        end
    end

    // compare against the registered deadline read
    assign past_due   = (now_reg > rd_data_reg);
    assign over_time  = now_reg - rd_data_reg;
    assign slot_valid = in_use_reg[slot_reg];
    assign scan_hit   = in_use_reg[scan_idx_reg] && armed_reg[scan_idx_reg] && past_due;

    // memory read address: addressed slot on accept, first slot for a tick,
    // next slot while scanning
    always_comb begin
        if (cmd.load) begin
            rd_addr = (s_op == mdw_pkg::OP_TICK) ? '0 : in_slot;
        end else begin
            rd_addr = scan_idx_reg + SB'(1);
        end
    end
    assign rd_en = cmd.load || (cmd.scan_step && !scan_last);

    // memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[slot_reg] <= mem_wdata;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // item latch
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg      <= s_op;
            slot_reg    <= in_slot;
            timeout_reg <= in_timeout;
            now_reg     <= in_now;
        end
    end

    // operation and scan logic
    always_comb begin
        in_use_next     = in_use_reg;
        armed_next      = armed_reg;
        fifo_next       = fifo_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        scan_idx_next   = scan_idx_reg;
        hold_valid_next = hold_valid_reg;
        hold_slot_next  = hold_slot_reg;
        hold_late_next  = hold_late_reg;
        mem_we          = 1'b0;
        mem_wdata       = arm_deadline;
        push            = 1'b0;
        push_ev         = mdw_pkg::EV_GRANT;
        push_st         = mdw_pkg::ST_OK;
        push_slot       = slot_reg;
        push_late       = '0;
        push_last       = 1'b1;

        // tick start
        if (cmd.load && (s_op == mdw_pkg::OP_TICK)) begin
            scan_idx_next   = '0;
            hold_valid_next = 1'b0;
        end

        // single-result operations
        if (cmd.exec) begin
            push = 1'b1;
            unique case (op_reg)
                mdw_pkg::OP_ALLOC: begin
                    push_ev = mdw_pkg::EV_GRANT;
                    if (count_reg == '0) begin
                        push_st   = mdw_pkg::ST_NOFREE;
                        push_slot = '0;
                    end else begin
                        push_slot                     = fifo_reg[head_reg];
                        in_use_next[fifo_reg[head_reg]] = 1'b1;
                        armed_next[fifo_reg[head_reg]]  = 1'b0;
                        head_next  = (head_reg == SB'(NS - 1)) ? '0 : head_reg + SB'(1);
                        count_next = count_reg - CB'(1);
                    end
                end
                mdw_pkg::OP_RELEASE: begin
                    push_ev = mdw_pkg::EV_RELEASE;
                    if (!slot_valid) begin
                        push_st = mdw_pkg::ST_UNUSED;
                    end else begin
                        armed_next[slot_reg]  = 1'b0;
                        in_use_next[slot_reg] = 1'b0;
                        fifo_next[tail_reg]   = slot_reg;
                        tail_next  = (tail_reg == SB'(NS - 1)) ? '0 : tail_reg + SB'(1);
                        count_next = count_reg + CB'(1);
                    end
                end
                mdw_pkg::OP_ARM: begin
                    push_ev = mdw_pkg::EV_ARM;
                    if (!slot_valid) begin
                        push_st = mdw_pkg::ST_UNUSED;
                    end else begin
                        mem_we               = 1'b1;
                        armed_next[slot_reg] = 1'b1;
                    end
                end
                mdw_pkg::OP_CONFIRM: begin
                    push_ev = mdw_pkg::EV_ONTIME;
                    if (!slot_valid) begin
                        push_st = mdw_pkg::ST_UNUSED;
                    end else begin
                        if (armed_reg[slot_reg] && past_due) begin
                            push_ev   = mdw_pkg::EV_LATE;
                            push_late = over_time;
                        end
                        armed_next[slot_reg] = 1'b0;
                    end
                end
                default: push = 1'b0;
            endcase
        end

        // scan: an expired slot is held until the next one shows up or the
        // scan ends, so the final result can carry last
        if (cmd.scan_step) begin
            if (scan_hit) begin
                if (hold_valid_reg) begin
                    push      = 1'b1;
                    push_ev   = mdw_pkg::EV_EXPIRED;
                    push_slot = hold_slot_reg;
                    push_late = hold_late_reg;
                    push_last = 1'b0;
                end
                hold_valid_next          = 1'b1;
                hold_slot_next           = scan_idx_reg;
                hold_late_next           = over_time;
                armed_next[scan_idx_reg] = 1'b0;
            end
            if (!scan_last) begin
                scan_idx_next = scan_idx_reg + SB'(1);
            end
        end

        // end of scan
        if (cmd.flush) begin
            push    = 1'b1;
            push_ev = mdw_pkg::EV_EXPIRED;
            if (hold_valid_reg) begin
                push_slot = hold_slot_reg;
                push_late = hold_late_reg;
            end else begin
                push_st   = mdw_pkg::ST_NONE;
                push_slot = '0;
            end
            hold_valid_next = 1'b0;
        end
    end

    // output valid
    always_comb begin
        if (push) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_use_reg     <= '0;
            armed_reg      <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= CB'(NS);
            scan_idx_reg   <= '0;
            hold_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            for (int i = 0; i < NS; i++) begin
                fifo_reg[i] <= SB'(i);
            end
        end else begin
            in_use_reg     <= in_use_next;
            armed_reg      <= armed_next;
            fifo_reg       <= fifo_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            scan_idx_reg   <= scan_idx_next;
            hold_valid_reg <= hold_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        hold_slot_reg <= hold_slot_next;
        hold_late_reg <= hold_late_next;
        if (push) begin
            ev_reg    <= push_ev;
            st_reg    <= push_st;
            rslot_reg <= push_slot;
            late_reg  <= push_late;
            last_reg  <= push_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0, late_reg, rslot_reg};
    assign m_tuser  = {st_reg, ev_reg};
    assign m_tlast  = last_reg;

    assign stat.op         = op_reg;
    assign stat.out_free   = out_free;
    assign stat.scan_hit   = scan_hit;
    assign stat.scan_last  = scan_last;
    assign stat.hold_valid = hold_valid_reg;
    assign stat.free_count = count_reg;
    assign stat.in_use     = in_use_reg;
    assign stat.armed      = armed_reg;

endmodule
`default_nettype wire
